### src/ofe_pkg.sv
// Shared types and constants for the one-euro filter.
package ofe_pkg;

  localparam int unsigned RegW       = 32;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CntW       = 5;
  localparam int unsigned TwoPiShift = 29;
  localparam int unsigned WW         = 35;
  localparam int unsigned DenW       = 36;

  localparam logic [RegW-1:0] TwoPiQ29 = 32'd3373259426;
  localparam logic [RegW-1:0] SatPos   = 32'h7fff_ffff;
  localparam logic [RegW-1:0] SatNeg   = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_RATE       = 8'd0,
    CFG_MIN_CUTOFF        = 8'd1,
    CFG_SPEED_GAIN        = 8'd2,
    CFG_DERIVATIVE_CUTOFF = 8'd3
  } cfg_idx_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_W_D,
    ST_DIV_D,
    ST_BLEND_D,
    ST_GAIN,
    ST_W_V,
    ST_DIV_V,
    ST_BLEND_V,
    ST_OUT
  } ofe_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

### src/ofe_alu.sv
// Shared bit-serial multiplier and restoring divider for the one-euro filter.
module ofe_alu import ofe_pkg::*; #(
  parameter int unsigned DATA_W    = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  alu_req_t                         req_i,
  input  logic [DATA_W-1:0]                a_i,
  input  logic [RegW-1:0]                  b_i,
  input  logic [DenW+FRAC_BITS-1:0]        num_i,
  input  logic [DenW-1:0]                  den_i,
  output logic                             done_o,
  output logic [DATA_W+RegW-1:0]           prod_o,
  output logic [FRAC_BITS:0]               quo_o
);

  localparam int unsigned PW = DATA_W + RegW;
  localparam int unsigned NW = DenW + FRAC_BITS;
  localparam int unsigned QW = FRAC_BITS + 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  alu_op_e         op_q, op_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DenW-1:0] den_q, den_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [QW-1:0]   qn_q, qn_d;

  logic [DATA_W:0] acc_sum;
  logic [DenW:0]   trial;
  logic            ge;

  always_comb begin
    acc_sum = {1'b0, prod_q[PW-1:RegW]} + (prod_q[0] ? {1'b0, a_q} : '0);
    trial   = {rem_q, qn_q[QW-1]};
    ge      = trial >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = busy_q && (cnt_q == '0);
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    den_d  = den_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    qn_d   = qn_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = a_i;
      den_d  = den_i;
      prod_d = {{DATA_W{1'b0}}, b_i};
      rem_d  = {1'b0, num_i[NW-1:QW]};
      qn_d   = num_i[QW-1:0];
      cnt_d  = (req_i.op == ALU_MUL) ? CntW'(RegW - 1) : CntW'(QW - 1);
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        prod_d = {acc_sum, prod_q[RegW-1:1]};
      end else begin
        rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
        qn_d  = {qn_q[QW-2:0], ge};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    den_q  <= den_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    qn_q   <= qn_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;
  assign quo_o  = qn_q;

endmodule

### src/one_euro_filter.sv
// One-euro adaptive low-pass filter top level with its step sequencer.
// The filter takes one word at a time and holds s_axis_tready low until the
// result word has been taken. The first sample after reset passes straight
// through, and m_axis_tvalid rises in the cycle after it is accepted. Every
// later sample runs through one shared bit-serial multiplier and restoring
// divider: six products and two divisions in turn, after which m_axis_tvalid
// rises. Configuration writes are always taken and must only be issued while
// no word is in flight.
module one_euro_filter import ofe_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // Fields from bit 0: smoothed.
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]                      cfg_index_i,
  input  logic [RegW-1:0]                         cfg_data_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned DW = (SAMPLE_WIDTH > RegW) ? SAMPLE_WIDTH : RegW;
  localparam int unsigned BW = DW + 1;
  localparam int unsigned PW = DW + RegW;
  localparam int unsigned TW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned NW = DenW + FRAC_BITS;
  localparam logic [RegW-1:0] OneFx    = RegW'(1) << FRAC_BITS;
  localparam logic [RegW-1:0] RateInit = RegW'(120) << FRAC_BITS;
  localparam logic [PW-1:0]   HalfFx   = PW'(1) << (FRAC_BITS - 1);

  ofe_state_e state_q, state_d;
  logic       launched_q, launched_d;
  logic       primed_q, primed_d;
  logic [RegW-1:0] rate_q, rate_d;
  logic [RegW-1:0] mincut_q, mincut_d;
  logic [RegW-1:0] gain_q, gain_d;
  logic [RegW-1:0] dcut_q, dcut_d;

  logic [SW-1:0]        x_q, x_d;
  logic [SW-1:0]        prev_q, prev_d;
  logic [SW-1:0]        sv_q, sv_d;
  logic [RegW-1:0]      srate_q, srate_d;
  logic [RegW-1:0]      deriv_q, deriv_d;
  logic [RegW-1:0]      cut_q, cut_d;
  logic [WW-1:0]        w_q, w_d;
  logic [FRAC_BITS-1:0] alpha_q, alpha_d;

  alu_req_t             alu_req;
  logic                 alu_start;
  alu_op_e              alu_op;
  logic [DW-1:0]        alu_a;
  logic [RegW-1:0]      alu_b;
  logic [NW-1:0]        alu_num;
  logic [DenW-1:0]      alu_den;
  logic                 alu_done;
  logic [PW-1:0]        prod;
  logic [FRAC_BITS:0]   quo;

  logic                 s_fire, cfg_fire;
  logic [SW-1:0]        sample;

  logic [SW:0]          rd;
  logic                 rneg;
  logic [SW:0]          rmag_full;
  logic [PW-FRAC_BITS-1:0] rp;
  logic [RegW-1:0]      rlim, rsat, deriv_new;

  logic [BW-1:0]        bprev, bx, bd, bmag_full, bres;
  logic                 bneg;
  logic [PW-1:0]        rsum;
  logic [DW-1:0]        delta;

  logic [RegW-1:0]      sabs;
  logic [2*RegW:0]      csum;
  logic [RegW-1:0]      cut_new;
  logic [FRAC_BITS-1:0] alpha_new;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = TW'(sv_q);
  assign sample        = s_axis_tdata[SW-1:0];
  assign alu_req       = '{start: alu_start, op: alu_op};

  // Rate of change: |x - prev| * rate >> F, saturated to signed 32 bits.
  always_comb begin
    rd        = {x_q[SW-1], x_q} - {prev_q[SW-1], prev_q};
    rneg      = rd[SW];
    rmag_full = rneg ? (~rd + 1'b1) : rd;
    rp        = prod[PW-1:FRAC_BITS];
    rlim      = rneg ? SatNeg : SatPos;
    rsat      = (rp > (PW-FRAC_BITS)'(rlim)) ? rlim : rp[RegW-1:0];
    deriv_new = rneg ? (~rsat + 1'b1) : rsat;
  end

  // Blend operands and the rounded step toward the new value.
  always_comb begin
    if (state_q == ST_BLEND_D) begin
      bprev = {{(BW-RegW){srate_q[RegW-1]}}, srate_q};
      bx    = {{(BW-RegW){deriv_q[RegW-1]}}, deriv_q};
    end else begin
      bprev = {{(BW-SW){sv_q[SW-1]}}, sv_q};
      bx    = {{(BW-SW){x_q[SW-1]}}, x_q};
    end
    bd        = bx - bprev;
    bneg      = bd[DW];
    bmag_full = bneg ? (~bd + 1'b1) : bd;
    rsum      = prod + HalfFx;
    delta     = rsum[FRAC_BITS +: DW];
    bres      = bneg ? (bprev - {1'b0, delta}) : (bprev + {1'b0, delta});
  end

  always_comb begin
    sabs      = srate_q[RegW-1] ? (~srate_q + 1'b1) : srate_q;
    csum      = (2*RegW+1)'(prod[2*RegW-1:FRAC_BITS]) + (2*RegW+1)'(mincut_q);
    cut_new   = (csum > (2*RegW+1)'({RegW{1'b1}})) ? {RegW{1'b1}} : csum[RegW-1:0];
    alpha_new = quo[FRAC_BITS] ? {FRAC_BITS{1'b1}} : quo[FRAC_BITS-1:0];
    alu_den   = DenW'(w_q) + DenW'(rate_q);
    alu_num   = {1'b0, w_q, {FRAC_BITS{1'b0}}} + NW'(alu_den[DenW-1:1]);
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_MUL;
    alu_a  = bmag_full[DW-1:0];
    alu_b  = RegW'(alpha_q);
    case (state_q)
      ST_RATE: begin
        alu_a = DW'(rmag_full[SW-1:0]);
        alu_b = rate_q;
      end
      ST_W_D: begin
        alu_a = DW'(dcut_q);
        alu_b = TwoPiQ29;
      end
      ST_GAIN: begin
        alu_a = DW'(sabs);
        alu_b = gain_q;
      end
      ST_W_V: begin
        alu_a = DW'(cut_q);
        alu_b = TwoPiQ29;
      end
      ST_DIV_D, ST_DIV_V: begin
        alu_op = ALU_DIV;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    primed_d   = primed_q;
    alu_start  = 1'b0;
    x_d        = x_q;
    prev_d     = prev_q;
    sv_d       = sv_q;
    srate_d    = srate_q;
    deriv_d    = deriv_q;
    cut_d      = cut_q;
    w_d        = w_q;
    alpha_d    = alpha_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          x_d = sample;
          if (primed_q) begin
            state_d = ST_RATE;
          end else begin
            state_d  = ST_OUT;
            srate_d  = '0;
            prev_d   = sample;
            sv_d     = sample;
            primed_d = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        alu_start  = !launched_q;
        launched_d = 1'b1;
        if (alu_done) begin
          launched_d = 1'b0;
          case (state_q)
            ST_RATE: begin
              deriv_d = deriv_new;
              state_d = ST_W_D;
            end
            ST_W_D: begin
              w_d     = prod[TwoPiShift +: WW];
              state_d = ST_DIV_D;
            end
            ST_DIV_D: begin
              alpha_d = alpha_new;
              state_d = ST_BLEND_D;
            end
            ST_BLEND_D: begin
              srate_d = bres[RegW-1:0];
              state_d = ST_GAIN;
            end
            ST_GAIN: begin
              cut_d   = cut_new;
              state_d = ST_W_V;
            end
            ST_W_V: begin
              w_d     = prod[TwoPiShift +: WW];
              state_d = ST_DIV_V;
            end
            ST_DIV_V: begin
              alpha_d = alpha_new;
              state_d = ST_BLEND_V;
            end
            ST_BLEND_V: begin
              sv_d    = bres[SW-1:0];
              prev_d  = x_q;
              state_d = ST_OUT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // Register writes; zero is stored as 1.0 for the frequency registers.
  always_comb begin
    rate_d   = rate_q;
    mincut_d = mincut_q;
    gain_d   = gain_q;
    dcut_d   = dcut_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_SAMPLE_RATE:       rate_d   = (cfg_data_i == '0) ? OneFx : cfg_data_i;
        CFG_MIN_CUTOFF:        mincut_d = (cfg_data_i == '0) ? OneFx : cfg_data_i;
        CFG_SPEED_GAIN:        gain_d   = cfg_data_i;
        CFG_DERIVATIVE_CUTOFF: dcut_d   = (cfg_data_i == '0) ? OneFx : cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      launched_q <= 1'b0;
      primed_q   <= 1'b0;
      rate_q     <= RateInit;
      mincut_q   <= OneFx;
      gain_q     <= '0;
      dcut_q     <= OneFx;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      primed_q   <= primed_d;
      rate_q     <= rate_d;
      mincut_q   <= mincut_d;
      gain_q     <= gain_d;
      dcut_q     <= dcut_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prev_q  <= prev_d;
    sv_q    <= sv_d;
    srate_q <= srate_d;
    deriv_q <= deriv_d;
    cut_q   <= cut_d;
    w_q     <= w_d;
    alpha_q <= alpha_d;
  end

  ofe_alu #(
    .DATA_W   (DW),
    .FRAC_BITS(FRAC_BITS)
  ) u_ofe_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .num_i (alu_num),
    .den_i (alu_den),
    .done_o(alu_done),
    .prod_o(prod),
    .quo_o (quo)
  );

endmodule

### src/ofe_checker.sv
// Port-level checker for the one-euro filter and its bind to the top level.
module ofe_checker #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  logic s_fire, m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // A word in flight blocks the input until its result is taken.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input still ready after a word was accepted");

  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |=> (s_axis_tready && !m_axis_tvalid))
    else $error("filter not idle after the result word was taken");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed or dropped");

endmodule

bind one_euro_filter ofe_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ofe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### tb/tb_one_euro_filter.sv
// Self-checking stream testbench for the one-euro filter with a bit-exact predictor.
module tb_one_euro_filter import ofe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned TwoPiFrac    = 29;
  localparam logic [63:0] TwoPiFx      = 64'd3373259426;
  localparam logic [63:0] OneFx        = 64'd1 << FracBits;
  localparam int unsigned RandomItems  = 1650;
  localparam int unsigned HoldAt       = 300;
  localparam int unsigned HoldCycles   = 4000;
  localparam int unsigned TailCycles   = 300;
  localparam int unsigned CycleLimit   = 5_000_000;
  localparam int unsigned FirstUnmapped = CFG_DERIVATIVE_CUTOFF + 1;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = '1;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_SAMPLE,
    ROW_KNOWN
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SHUT
  } rx_mode_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    logic [31:0]        want;
  } row_t;

  localparam row_t Plan [33] = '{
    '{ROW_KNOWN,  '0, 32'h7fff_ffff, 32'h7fff_ffff},
    '{ROW_KNOWN,  '0, 32'h7fff_ffff, 32'h7fff_ffff},
    '{ROW_SAMPLE, '0, 32'h8000_0000, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, '0},
    '{ROW_CFG, CFG_SPEED_GAIN,  32'hffff_ffff, '0},
    '{ROW_CFG, CFG_SAMPLE_RATE, 32'h0000_0000, '0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, '0},
    '{ROW_SAMPLE, '0, 32'h0000_3039, '0},
    '{ROW_CFG, CFG_MIN_CUTOFF,        32'h0000_0000, '0},
    '{ROW_CFG, CFG_DERIVATIVE_CUTOFF, 32'h0000_0000, '0},
    '{ROW_CFG, CfgUnmapped,           32'h1234_5678, '0},
    '{ROW_CFG, CFG_SAMPLE_RATE,       32'hffff_ffff, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0001, '0},
    '{ROW_SAMPLE, '0, 32'hffff_ffff, '0},
    '{ROW_SAMPLE, '0, 32'h4000_0000, '0},
    '{ROW_SAMPLE, '0, 32'hc000_0000, '0},
    '{ROW_CFG, CFG_MIN_CUTOFF,        32'hffff_ffff, '0},
    '{ROW_CFG, CFG_DERIVATIVE_CUTOFF, 32'hffff_ffff, '0},
    '{ROW_CFG, CFG_SPEED_GAIN,        32'h0000_0000, '0},
    '{ROW_CFG, CFG_SAMPLE_RATE,       32'h0000_0001, '0},
    '{ROW_SAMPLE, '0, 32'h1234_5678, '0},
    '{ROW_SAMPLE, '0, 32'hedcb_a987, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, '0},
    '{ROW_CFG, CFG_SAMPLE_RATE,       32'h0078_0000, '0},
    '{ROW_CFG, CFG_MIN_CUTOFF,        32'h0001_0000, '0},
    '{ROW_CFG, CFG_SPEED_GAIN,        32'h0000_8000, '0},
    '{ROW_CFG, CFG_DERIVATIVE_CUTOFF, 32'h0001_0000, '0},
    '{ROW_SAMPLE, '0, 32'h0001_0000, '0},
    '{ROW_SAMPLE, '0, 32'h0001_8000, '0},
    '{ROW_SAMPLE, '0, 32'hfffe_0000, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [RegW-1:0]    cfg_data_i;

  logic [63:0] cfg_rate, cfg_min_cut, cfg_gain, cfg_dcut;
  longint      last_raw, last_out, last_speed;
  bit          seen_first;

  logic [31:0] smoothed_due [$];
  int unsigned items_sent, directed_sent, results_seen, mismatches;
  int unsigned reg_writes, settings, cycle_count;

  always #5ns clk_i = ~clk_i;

  one_euro_filter dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  function automatic logic [63:0] alpha_for(logic [63:0] cut);
    logic [63:0] w, den, a;
    w   = (cut * TwoPiFx) >> TwoPiFrac;
    den = w + cfg_rate;
    a   = ((w << FracBits) + den / 2) / den;
    if (a > OneFx - 1) a = OneFx - 1;
    return a;
  endfunction

  function automatic longint mix(longint prev, longint x, logic [63:0] a);
    logic        neg;
    logic [63:0] mag, delta;
    neg   = x < prev;
    mag   = neg ? prev - x : x - prev;
    delta = a * (mag >> FracBits) + ((a * (mag & (OneFx - 1)) + (OneFx >> 1)) >> FracBits);
    return neg ? prev - $signed(delta) : prev + $signed(delta);
  endfunction

  function automatic longint speed_of(longint x);
    longint       d;
    logic         neg;
    logic [63:0]  mag, lim;
    logic [127:0] p;
    d = x - last_raw;
    if (d == 0) return 0;
    neg = d < 0;
    mag = neg ? -d : d;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    p   = (128'(mag) * 128'(cfg_rate)) >> FracBits;
    if (p > 128'(lim)) p = 128'(lim);
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic [31:0] euro_step(logic [31:0] raw);
    longint      x, ed, res;
    logic [63:0] mag_ed, cut;
    x = $signed(raw);
    if (seen_first) begin
      ed     = mix(last_speed, speed_of(x), alpha_for(cfg_dcut));
      mag_ed = (ed < 0) ? -ed : ed;
      cut    = ((cfg_gain * mag_ed) >> FracBits) + cfg_min_cut;
      if (cut > 64'hffff_ffff) cut = 64'hffff_ffff;
      last_speed = ed;
      res = mix(last_out, x, alpha_for(cut));
    end else begin
      last_speed = 0;
      res = x;
    end
    last_raw   = x;
    last_out   = res;
    seen_first = 1'b1;
    return res[31:0];
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    case (idx)
      CFG_SAMPLE_RATE:       cfg_rate    = (val == 0) ? OneFx : 64'(val);
      CFG_MIN_CUTOFF:        cfg_min_cut = (val == 0) ? OneFx : 64'(val);
      CFG_SPEED_GAIN:        cfg_gain    = 64'(val);
      CFG_DERIVATIVE_CUTOFF: cfg_dcut    = (val == 0) ? OneFx : 64'(val);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_reg(cfg_idx_e idx);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: begin
        case (idx)
          CFG_SAMPLE_RATE: return $urandom_range(30 << 16, 1000 << 16);
          CFG_MIN_CUTOFF:  return $urandom_range(32'h0000_0290, 10 << 16);
          CFG_SPEED_GAIN:  return $urandom_range(0, 2 << 16);
          default:         return $urandom_range(32'h0000_1999, 10 << 16);
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 20);
    return $urandom_range(21, 300);
  endfunction

  task automatic report_bad(string note, int unsigned n, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 100) $display("word %0d: %s, smoothed %h, expected %h", n, note, got, want);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic send_sample(logic [31:0] raw, bit known, logic [31:0] want);
    logic [31:0] guess;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    guess = euro_step(raw);
    smoothed_due.push_back(known ? want : guess);
    items_sent++;
  endtask

  task automatic idle_sender(int unsigned n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (smoothed_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (smoothed_due.size() == 0) begin
        report_bad("no word pending", results_seen, m_axis_tdata, '0);
      end else if (m_axis_tdata !== smoothed_due[0]) begin
        report_bad("wrong value", results_seen, m_axis_tdata, smoothed_due[0]);
        void'(smoothed_due.pop_front());
      end else begin
        void'(smoothed_due.pop_front());
      end
      results_seen++;
    end
  end

  initial begin
    rx_mode_e    mode;
    int unsigned rx_left;
    bit          held;
    mode    = RX_OPEN;
    rx_left = 0;
    held    = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= HoldAt) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          mode    = rx_mode_e'($urandom_range(0, 2));
          rx_left = (mode == RX_SHUT) ? $urandom_range(1, 60) : $urandom_range(100, 600);
        end
        rx_left--;
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    bit          in_cfg, calm;
    int unsigned burst_left, phase_len, step_bits, target;
    logic [31:0] level, step, raw;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    cfg_rate    = 64'd120 << FracBits;
    cfg_min_cut = OneFx;
    cfg_gain    = 0;
    cfg_dcut    = OneFx;
    last_raw    = 0;
    last_out    = 0;
    last_speed  = 0;
    seen_first  = 1'b0;
    items_sent = 0; results_seen = 0; mismatches = 0; reg_writes = 0; settings = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 1'b0;
    foreach (Plan[i]) begin
      if (Plan[i].kind == ROW_CFG) begin
        if (!in_cfg) begin
          s_axis_tvalid <= 1'b0;
          drain();
          settings++;
        end
        in_cfg = 1'b1;
        write_reg(Plan[i].idx, Plan[i].data);
      end else begin
        if (in_cfg) cfg_valid_i <= 1'b0;
        in_cfg = 1'b0;
        send_sample(Plan[i].data, Plan[i].kind == ROW_KNOWN, Plan[i].want);
        idle_sender($urandom_range(0, 3));
      end
    end
    directed_sent = items_sent;

    target = items_sent + RandomItems;
    level  = $urandom;
    while (items_sent < target) begin
      s_axis_tvalid <= 1'b0;
      drain();
      settings++;
      write_reg(CFG_SAMPLE_RATE, pick_reg(CFG_SAMPLE_RATE));
      write_reg(CFG_MIN_CUTOFF, pick_reg(CFG_MIN_CUTOFF));
      write_reg(CFG_SPEED_GAIN, pick_reg(CFG_SPEED_GAIN));
      write_reg(CFG_DERIVATIVE_CUTOFF, pick_reg(CFG_DERIVATIVE_CUTOFF));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CfgIdxW'($urandom_range(FirstUnmapped, CfgUnmapped)), $urandom);
      end
      cfg_valid_i <= 1'b0;

      phase_len  = $urandom_range(40, 200);
      if (phase_len > target - items_sent) phase_len = target - items_sent;
      step_bits  = $urandom_range(2, 24);
      calm       = $urandom_range(0, 3) == 0;
      burst_left = 0;
      repeat (phase_len) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          idle_sender(calm ? 0 : pick_gap());
        end
        burst_left--;
        case ($urandom_range(0, 19))
          0: raw = $urandom;
          1: raw = level;
          2: raw = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
          default: begin
            step  = $urandom & ((32'd1 << step_bits) - 1);
            level = $urandom_range(0, 1) ? level + step : level - step;
            raw   = level;
          end
        endcase
        send_sample(raw, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d samples (%0d directed) over %0d register settings and %0d register writes.",
             items_sent, directed_sent, settings, reg_writes);
    $display("Checked %0d smoothed words in %0d cycles, %0d mismatches.",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0 && smoothed_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
